// File: rtl/nec_pkg.sv
// Shared types, sizes and helpers for the epsilon-closure engine.
`default_nettype none

package nec_pkg;

  localparam int ROW_W       = 63;
  localparam int IDX_W       = 6;
  localparam int MAX_STATES  = 63;

  typedef struct packed {
    logic [ROW_W-1:0] row_mask;
    logic             last_row;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0] state_index;
    logic [ROW_W-1:0] closure;
    logic             is_last;
    logic             error;
  } out_beat_t;

  // Index of the lowest set bit; ROW_W when none is set.
  function automatic logic [IDX_W-1:0] lowest_bit(input logic [ROW_W-1:0] v);
    logic [IDX_W-1:0] n;
    n = IDX_W'(ROW_W);
    for (int j = ROW_W - 1; j >= 0; j--) begin
      if (v[j]) begin
        n = IDX_W'(j);
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: rtl/nec_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module nec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/nfa_epsilon_closure.sv
// Epsilon-closure engine: loads an NFA adjacency matrix and emits each state's closure.
`default_nettype none

// Rows stream in one beat per cycle while in_stall is low and are written to a
// single adjacency RAM in state order. The beat with last_row set starts the
// closure phase, during which in_stall is high. For each loaded state c the
// engine walks its pending set one state at a time: pick the lowest pending
// state and read its row, then merge the registered row into the visited and
// pending sets, a pace set by the RAM's single read port and registered read
// data. Results leave through an output register, in state order, with is_last
// on the final one. A run of more than MAX_STATES rows yields one error beat
// (state 0, closure 0, is_last and error set). Adjacency bits at or above the
// loaded row count are ignored.
module nfa_epsilon_closure #(
  parameter int MAX_STATES = nec_pkg::MAX_STATES
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire nec_pkg::in_beat_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output nec_pkg::out_beat_t     out_data
);

  localparam int ROW_W = nec_pkg::ROW_W;
  localparam int IDX_W = nec_pkg::IDX_W;
  localparam int AW    = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int CNT_W = $clog2(MAX_STATES + 2);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_PICK = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_ERR  = 3'd4;

  logic [2:0]       state;
  logic [CNT_W-1:0] rows_loaded;
  logic             overflow;
  logic [IDX_W-1:0] cur;
  logic [ROW_W-1:0] visited;
  logic [ROW_W-1:0] pending;
  logic [ROW_W-1:0] valid_mask;

  logic             in_acc;
  logic             out_free;
  logic             out_load;
  logic             store_row;
  logic [CNT_W-1:0] count_next;
  logic [ROW_W-1:0] mask_next;
  logic [IDX_W-1:0] pick;
  logic [ROW_W-1:0] rd_data;
  logic [ROW_W-1:0] reach;
  logic             cur_last;
  logic [IDX_W-1:0] cur_inc;

  assign in_stall  = (state != S_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = out_free && ((state == S_EMIT) || (state == S_ERR));
  assign store_row = (rows_loaded < CNT_W'(MAX_STATES));
  assign count_next = rows_loaded + CNT_W'(1);
  assign pick      = nec_pkg::lowest_bit(pending);
  assign reach     = rd_data & valid_mask & ~visited;
  assign cur_inc   = cur + IDX_W'(1);
  assign cur_last  = (CNT_W'(cur) + CNT_W'(1) == rows_loaded);

  always_comb begin
    for (int j = 0; j < ROW_W; j++) begin
      mask_next[j] = (j < int'(count_next));
    end
  end

  nec_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_STATES)
  ) u_adj (
    .clk   (clk),
    .we    (in_acc && store_row),
    .waddr (rows_loaded[AW-1:0]),
    .wdata (in_data.row_mask),
    .raddr (pick[AW-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      rows_loaded <= '0;
      overflow    <= 1'b0;
      cur         <= '0;
      visited     <= '0;
      pending     <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (store_row) begin
              rows_loaded <= count_next;
            end else begin
              overflow    <= 1'b1;
              rows_loaded <= CNT_W'(MAX_STATES + 1);
            end
            if (in_data.last_row) begin
              if (!store_row || overflow) begin
                state <= S_ERR;
              end else begin
                state      <= S_PICK;
                cur        <= '0;
                visited    <= ROW_W'(1);
                pending    <= ROW_W'(1);
                valid_mask <= mask_next;
              end
            end
          end
        end
        S_PICK: begin
          if (pending == '0) begin
            state <= S_EMIT;
          end else begin
            pending <= pending & ~(ROW_W'(1) << pick);
            state   <= S_WAIT;
          end
        end
        S_WAIT: begin
          // merge the row read for the picked state
          visited <= visited | reach;
          pending <= pending | reach;
          state   <= S_PICK;
        end
        S_EMIT: begin
          if (out_free) begin
            out_data.state_index <= cur;
            out_data.closure     <= visited;
            out_data.is_last     <= cur_last;
            out_data.error       <= 1'b0;
            if (cur_last) begin
              rows_loaded <= '0;
              overflow    <= 1'b0;
              state       <= S_LOAD;
            end else begin
              cur     <= cur_inc;
              visited <= ROW_W'(1) << cur_inc;
              pending <= ROW_W'(1) << cur_inc;
              state   <= S_PICK;
            end
          end
        end
        S_ERR: begin
          if (out_free) begin
            out_data.state_index <= '0;
            out_data.closure     <= '0;
            out_data.is_last     <= 1'b1;
            out_data.error       <= 1'b1;
            rows_loaded          <= '0;
            overflow             <= 1'b0;
            state                <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pending_in_visited: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |-> ((pending & ~visited) == '0))
    else $error("pending state outside visited set");

  a_wait_after_pick: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT) |-> ($past(state) == S_PICK))
    else $error("merge without a row read");

  a_error_beat_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.error) |-> (out_data.closure == '0 && out_data.is_last))
    else $error("error beat carries a closure");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (rows_loaded <= CNT_W'(MAX_STATES + 1)))
    else $error("row count beyond saturation");
`endif

endmodule

`default_nettype wire
